// File: design/tcft_pkg.sv
// Shared types, constants and trend step function for the temperature change filter.
package tcft_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int HOLD_W   = 20;

    localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(10000);

    typedef enum logic [1:0] {
        TREND_STALLED = 2'd0,
        TREND_RISEN   = 2'd1,
        TREND_FALLEN  = 2'd2
    } trend_t;

    // One filter result as handed from the core to the output register.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered;
        trend_t                     trend;
    } tcft_result_t;

    typedef struct packed {
        trend_t trend_now;
        trend_t trend_cand;
    } tcft_trend_state_t;

    // One step of the trend machine on a change of candidate value.
    function automatic tcft_trend_state_t trend_step(
        input tcft_trend_state_t            cur,
        input logic signed [SAMPLE_W-1:0]   old_v,
        input logic signed [SAMPLE_W-1:0]   new_v
    );
        tcft_trend_state_t nxt;
        nxt = cur;
        case (cur.trend_cand)
            TREND_RISEN:
            begin
                if (old_v > new_v)
                    nxt.trend_cand = TREND_STALLED;
                else
                    nxt.trend_now = TREND_RISEN;
            end
            TREND_FALLEN:
            begin
                if (old_v < new_v)
                    nxt.trend_cand = TREND_STALLED;
                else
                    nxt.trend_now = TREND_FALLEN;
            end
            TREND_STALLED:
            begin
                nxt.trend_cand = (old_v > new_v) ? TREND_FALLEN : TREND_RISEN;
                nxt.trend_now  = TREND_STALLED;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
        return nxt;
    endfunction

endpackage

// File: design/temperature_change_filter_trend.sv
// Top level: input register, filter core, output register and hold-time register.
// Each sample is registered in the input register, its result in the output register.
// Throughput: one sample per cycle unless stalled; the core updates its state as a sample
//   moves from the input register into the output register, so the next sample sees it.
// Reset (rst_n, async, active low): pipeline empty, filter not started, accepted
//   value 0, trend stalled with a risen candidate, hold_time_ms back to 10000.
module temperature_change_filter_trend (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_wr_en,
    input  logic [tcft_pkg::HOLD_W-1:0]          cfg_wr_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [tcft_pkg::SAMPLE_W-1:0] sample,
    input  logic [tcft_pkg::TIME_W-1:0]          now_ms,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [tcft_pkg::SAMPLE_W-1:0] filtered,
    output logic [1:0]                           trend
);
    import tcft_pkg::*;

    logic [HOLD_W-1:0] hold_reg;

    // Input register: holds one sample until the output register can take its result.
    logic                       s1_valid_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic [TIME_W-1:0]          s1_now_reg;

    logic         out_valid_reg;
    tcft_result_t out_result_reg;
    tcft_result_t core_result;

    logic out_free;
    logic advance;
    logic in_xfer;

    // Output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    // Input register is free when empty or moving forward this cycle.
    assign in_stall = s1_valid_reg && !out_free;
    assign in_xfer  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_reg <= HOLD_RESET;
        else if (cfg_wr_en)
            hold_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_xfer)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_sample_reg <= sample;
            s1_now_reg    <= now_ms;
        end
    end

    // State updates exactly once per sample, at the transfer into the output register.
    tcft_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .sample       (s1_sample_reg),
        .now_ms       (s1_now_reg),
        .hold_time_ms (hold_reg),
        .result       (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_result_reg <= core_result;
    end

    assign out_valid = out_valid_reg;
    assign filtered  = out_result_reg.filtered;
    assign trend     = out_result_reg.trend;

    // Back-pressure only when both registers are full.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && s1_valid_reg))
        else $error("input stalled without a full pipeline");

    // A transferred sample lands in the input register.
    a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> s1_valid_reg)
        else $error("accepted sample lost");

    // A held sample with an empty output register moves on in the next cycle.
    a_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_valid_reg) |=> out_valid)
        else $error("result not produced");

endmodule

// File: design/tcft_core.sv
// Filter state registers and the single-pass update logic for one sample.
module tcft_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic signed [tcft_pkg::SAMPLE_W-1:0] sample,
    input  logic [tcft_pkg::TIME_W-1:0]          now_ms,
    input  logic [tcft_pkg::HOLD_W-1:0]          hold_time_ms,
    output tcft_pkg::tcft_result_t               result
);
    import tcft_pkg::*;

    logic signed [SAMPLE_W-1:0] accepted_reg, accepted_next;
    logic signed [SAMPLE_W-1:0] candidate_reg, candidate_next;
    logic [TIME_W-1:0]          change_time_reg, change_time_next;
    logic                       started_reg, started_next;
    tcft_trend_state_t          trend_reg, trend_next;

    logic [TIME_W-1:0] change_mid;
    logic [TIME_W:0]   deadline;
    logic              expired;

    // A new candidate restarts the timer at this sample's timestamp.
    assign change_mid = (sample != candidate_reg) ? now_ms : change_time_reg;
    // Deadline sum is one bit wider so it never wraps.
    assign deadline = {1'b0, change_mid} + {{(TIME_W + 1 - HOLD_W){1'b0}}, hold_time_ms};
    assign expired  = {1'b0, now_ms} > deadline;

    always_comb
    begin
        accepted_next    = accepted_reg;
        candidate_next   = candidate_reg;
        change_time_next = change_time_reg;
        started_next     = started_reg;
        trend_next       = trend_reg;
        result.filtered  = sample;

        if (sample == accepted_reg)
        begin
            result.filtered = sample;
        end
        else if (!started_reg)
        begin
            accepted_next    = sample;
            change_time_next = now_ms;
            started_next     = 1'b1;
        end
        else
        begin
            if (sample != candidate_reg)
            begin
                candidate_next = sample;
                trend_next     = trend_step(trend_reg, accepted_reg, sample);
            end
            change_time_next = change_mid;
            if (expired)
            begin
                accepted_next    = sample;
                change_time_next = now_ms;
            end
            result.filtered = accepted_next;
        end
        result.trend = trend_next.trend_now;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted_reg    <= '0;
            candidate_reg   <= '0;
            change_time_reg <= '0;
            started_reg     <= 1'b0;
            trend_reg       <= '{trend_now: TREND_STALLED, trend_cand: TREND_RISEN};
        end
        else if (step)
        begin
            accepted_reg    <= accepted_next;
            candidate_reg   <= candidate_next;
            change_time_reg <= change_time_next;
            started_reg     <= started_next;
            trend_reg       <= trend_next;
        end
    end

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the temperature change filter with trend tracking.
`timescale 1ns / 1ps

module tb_top;
    import tcft_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 205;
    localparam int LONG_HOLD_OFF  = 80;

    // Holds the filter's expected state and the readings it has yet to produce.
    class filter_scoreboard;
        logic [HOLD_W-1:0]          hold_ms;
        logic signed [SAMPLE_W-1:0] acc_val;
        logic signed [SAMPLE_W-1:0] cand_val;
        logic [TIME_W-1:0]          chg_time;
        bit                         started;
        trend_t                     trend_now;
        trend_t                     trend_cand;
        tcft_result_t               expected_readings[$];
        int                         errors;
        int                         checked;

        function new();
            hold_ms    = HOLD_RESET;
            acc_val    = '0;
            cand_val   = '0;
            chg_time   = '0;
            started    = 1'b0;
            trend_now  = TREND_STALLED;
            trend_cand = TREND_RISEN;
            errors     = 0;
            checked    = 0;
        endfunction

        function void set_hold(logic [HOLD_W-1:0] v);
            hold_ms = v;
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        // Advance the filter state by one accepted sample and queue its reading.
        function void predict_sample(logic signed [SAMPLE_W-1:0] s, logic [TIME_W-1:0] t);
            tcft_result_t r;
            logic [TIME_W:0] deadline;
            if (s == acc_val)
            begin
                r.filtered = s;
            end
            else if (!started)
            begin
                acc_val    = s;
                chg_time   = t;
                started    = 1'b1;
                r.filtered = s;
            end
            else
            begin
                if (s != cand_val)
                begin
                    cand_val = s;
                    chg_time = t;
                    case (trend_cand)
                        TREND_RISEN:
                        begin
                            if (acc_val > s)
                                trend_cand = TREND_STALLED;
                            else
                                trend_now = TREND_RISEN;
                        end
                        TREND_FALLEN:
                        begin
                            if (acc_val < s)
                                trend_cand = TREND_STALLED;
                            else
                                trend_now = TREND_FALLEN;
                        end
                        TREND_STALLED:
                        begin
                            if (acc_val > s)
                                trend_cand = TREND_FALLEN;
                            else
                                trend_cand = TREND_RISEN;
                            trend_now = TREND_STALLED;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                // deadline kept one bit wider so it never wraps
                deadline = {1'b0, chg_time} + {{(TIME_W + 1 - HOLD_W){1'b0}}, hold_ms};
                if ({1'b0, t} > deadline)
                begin
                    acc_val  = s;
                    chg_time = t;
                end
                r.filtered = acc_val;
            end
            r.trend = trend_now;
            expected_readings.push_back(r);
        endfunction

        function void check_reading(logic signed [SAMPLE_W-1:0] f, logic [1:0] tr);
            tcft_result_t e;
            checked++;
            if (expected_readings.size() == 0)
            begin
                $display("%0t: unexpected reading filtered=%0d trend=%0d", $time, f, tr);
                errors++;
                return;
            end
            e = expected_readings.pop_front();
            if (f !== e.filtered)
            begin
                $display("%0t: filtered mismatch: expected %0d, actual %0d",
                         $time, e.filtered, f);
                errors++;
            end
            if (tr !== e.trend)
            begin
                $display("%0t: trend mismatch: expected %0d, actual %0d", $time, e.trend, tr);
                errors++;
            end
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_wr_en;
    logic [HOLD_W-1:0]           cfg_wr_data;
    logic                        in_valid;
    logic                        in_stall;
    logic signed [SAMPLE_W-1:0]  sample;
    logic [TIME_W-1:0]           now_ms;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [SAMPLE_W-1:0]  filtered;
    logic [1:0]                  trend;

    filter_scoreboard sb;

    // stimulus generator state
    logic [TIME_W-1:0]           cur_now;
    logic signed [SAMPLE_W-1:0]  level;
    logic signed [SAMPLE_W-1:0]  prev_level;
    int                          run_left;
    bit                          tx_idle_on;
    bit                          rx_idle_on;
    int                          hold_off_seq;
    int                          samples_sent;
    int                          quiet_cycles;

    always #5 clk = ~clk;

    temperature_change_filter_trend dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .filtered    (filtered),
        .trend       (trend)
    );

    // Receiver: random stall bursts, plus one long hold-off whenever the
    // sender bumps hold_off_seq. The hold-off is counted here, not by the sender.
    initial
    begin : receiver
        int stall_cnt;
        int seen_seq;
        stall_cnt = 0;
        seen_seq  = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_seq != seen_seq)
            begin
                seen_seq  = hold_off_seq;
                stall_cnt = LONG_HOLD_OFF;
            end
            else if (stall_cnt == 0 && rx_idle_on && $urandom_range(0, 99) < 12)
            begin
                stall_cnt = $urandom_range(1, 17);
            end
            if (stall_cnt > 0)
            begin
                out_stall <= 1'b1;
                stall_cnt--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Output monitor and watchdog. Values are sampled as they stood before the edge.
    always @(posedge clk)
    begin
        if (out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_reading(filtered, trend);
        if ((out_valid === 1'b1 && out_stall === 1'b0) || (in_valid && in_stall === 1'b0))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog: no transfer for %0d cycles, %0d readings outstanding",
                     $time, quiet_cycles, sb.pending());
            $display("tb_top NOT OK");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One input transfer; an optional idle burst goes in front of it.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic [TIME_W-1:0] t);
        if (tx_idle_on && $urandom_range(0, 99) < 12)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        now_ms   <= t;
        do
            @(posedge clk);
        while (in_stall);
        sb.predict_sample(s, t);
        samples_sent++;
    endtask

    // Drop valid and wait until every reading has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_hold(input logic [HOLD_W-1:0] v);
        drain();
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_hold(v);
    endtask

    // Mostly plateaus: a level held for a few samples with time stepping around
    // the hold time, so values get accepted, glitches get rejected and the trend
    // machine walks all its states. A small share is pure noise.
    task automatic next_sample(output logic signed [SAMPLE_W-1:0] s, output logic [TIME_W-1:0] t);
        int                         hold;
        logic [TIME_W-1:0]          step;
        logic signed [SAMPLE_W-1:0] tmp;
        hold = int'(sb.hold_ms);
        if ($urandom_range(0, 99) < 8)
        begin
            s = SAMPLE_W'($urandom);
            t = $urandom;
            return;
        end
        if (run_left == 0)
        begin
            run_left = $urandom_range(1, 9);
            case ($urandom_range(0, 5))
                0:
                begin
                    prev_level = level;
                    level      = SAMPLE_W'($urandom);
                end
                1, 2:
                begin
                    prev_level = level;
                    level      = level + SAMPLE_W'($urandom_range(1, 40));
                end
                3, 4:
                begin
                    prev_level = level;
                    level      = level - SAMPLE_W'($urandom_range(1, 40));
                end
                default:
                begin
                    // bounce back to the previous level
                    tmp        = level;
                    level      = prev_level;
                    prev_level = tmp;
                end
            endcase
        end
        case ($urandom_range(0, 5))
            0:       step = '0;
            1, 2:    step = $urandom_range(0, hold / 3 + 1);
            3:       step = hold;
            4:       step = hold + 1;
            default: step = $urandom_range(hold, 2 * hold + 2);
        endcase
        cur_now = cur_now + step;
        run_left--;
        s = level;
        t = cur_now;
    endtask

    initial
    begin : stimulus
        logic signed [SAMPLE_W-1:0] s;
        logic [TIME_W-1:0]          t;
        logic [HOLD_W-1:0]          hold_plan [8];
        sb           = new();
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        in_valid     = 1'b0;
        sample       = '0;
        now_ms       = '0;
        cur_now      = '0;
        level        = '0;
        prev_level   = '0;
        run_left     = 0;
        tx_idle_on   = 1'b1;
        rx_idle_on   = 1'b1;
        hold_off_seq = 0;
        samples_sent = 0;

        hold_plan = '{20'd0, 20'd1, 20'd25, 20'd400, 20'd1000000, 20'hFFFFF, 20'd0, 20'd3};
        hold_plan[6] = HOLD_W'($urandom_range(0, 20'hFFFFF));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, hold time still at its reset value of 10000 ms.
        send_sample(16'sd0, 32'd5);              // equal to reset value: no start
        send_sample(16'sd0, 32'd100);
        send_sample(16'sh7FFF, 32'd200);         // first differing sample starts filter
        send_sample(16'sh7FFF, 32'd300);         // equal to accepted: passes through
        send_sample(16'sh8000, 32'd400);         // risen candidate, drop -> candidate stalled
        send_sample(16'sh8000, 32'd10400);       // exactly at deadline: still held
        send_sample(16'sh8000, 32'd10401);       // one past: accepted
        send_sample(16'sd5, 32'd10500);          // stalled candidate -> risen, trend stalled
        send_sample(16'sd5, 32'd20501);
        send_sample(16'sd100, 32'd20600);        // risen candidate, rise -> trend risen
        send_sample(16'sd100, 32'd30601);
        send_sample(16'sd50, 32'd30700);         // risen candidate, drop -> candidate stalled
        send_sample(16'sd50, 32'd40701);
        send_sample(16'sd20, 32'd40800);         // stalled candidate -> fallen
        send_sample(16'sd20, 32'd50801);
        send_sample(16'sd10, 32'd50900);         // fallen candidate, drop -> trend fallen
        send_sample(16'sd30, 32'd50950);         // new candidate before accept, rise
        send_sample(16'sd30, 32'd60951);
        send_sample(16'shFFFF, 32'hFFFF_FFF0);   // change near the top of the time range
        send_sample(16'shFFFF, 32'hFFFF_FFFF);   // deadline lies past 2^32: waits
        send_sample(16'shFFFF, 32'h0000_0005);   // timestamp wrapped: still waits
        send_sample(16'sd7, 32'h0000_0010);      // new candidate restarts the timer
        send_sample(16'sd7, 32'd10017);
        send_sample(16'sd7, 32'd10018);

        // Random part: one phase per hold-time setting, extremes included.
        for (int ph = 0; ph < 8; ph++)
        begin
            write_hold(hold_plan[ph]);
            if (hold_plan[ph] == 20'hFFFFF)
                cur_now = 32'hFFF8_0000;         // let time wrap inside this phase
            tx_idle_on = (ph != 2 && ph != 7);
            rx_idle_on <= (ph != 7);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (ph == 2 && i == 40)
                    hold_off_seq <= hold_off_seq + 1;   // receiver backs off, block fills
                if (ph == 4 && i == 100)
                    drain();                            // sender waits for every reading
                next_sample(s, t);
                send_sample(s, t);
            end
        end

        drain();
        repeat (10) @(posedge clk);

        $display("Sent %0d samples over 9 hold-time settings, %0d readings checked,",
                 samples_sent, sb.checked);
        $display("  including timestamp wrap, long output back-pressure and full drains.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
